FILE: design/nta_pkg.sv
// Package for the normal to angle bytes core: request and result types, widths,
// arctangent table, root and CORDIC cell payloads and the quadrant pre-rotation. No dependencies.
package nta_pkg;

    localparam int CORDIC_STAGES = 16;
    localparam int ANG_TABLE_LEN = 24;
    localparam int SQRT_STEPS    = 24;
    localparam int STAGE_W       = 5;
    localparam int VEC_W         = 27;
    localparam int ANG_W         = 26;
    localparam int RAD_W         = 48;
    localparam int REM_W         = 27;
    localparam int ROOT_W        = 24;
    localparam int RND_W         = 11;

    typedef struct packed {
        logic signed [15:0] normal_x;
        logic signed [15:0] normal_y;
        logic signed [15:0] normal_z;
    } req_t;

    typedef struct packed {
        logic [7:0] azimuth_code;
        logic [7:0] elevation_code;
        logic       azimuth_wrapped;
    } res_t;

    typedef struct packed {
        logic [RAD_W-1:0]  rad;
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
        req_t              req;
    } sqrt_t;

    typedef struct packed {
        logic signed [VEC_W-1:0] a;
        logic signed [VEC_W-1:0] b;
        logic signed [ANG_W-1:0] ang;
        logic                    zero;
    } cordic_t;

    localparam logic signed [ANG_W-1:0] ATAN_DEG_Q16 [ANG_TABLE_LEN] = '{
        26'sd2949120, 26'sd1740967, 26'sd919879, 26'sd466945, 26'sd234379,
        26'sd117304, 26'sd58666, 26'sd29335, 26'sd14668, 26'sd7334,
        26'sd3667, 26'sd1833, 26'sd917, 26'sd458, 26'sd229, 26'sd115,
        26'sd57, 26'sd29, 26'sd14, 26'sd7, 26'sd4, 26'sd2, 26'sd1, 26'sd0
    };

    localparam logic signed [ANG_W-1:0] QUARTER_Q16 = 26'sd5898240;

    function automatic cordic_t prerotate(logic signed [VEC_W-1:0] b,
                                          logic signed [VEC_W-1:0] a);
        cordic_t v;
        v.zero = (a == '0) && (b == '0);
        v.a    = a;
        v.b    = b;
        v.ang  = '0;
        if (a < 0)
        begin
            if (b >= 0)
            begin
                v.a   = b;
                v.b   = -a;
                v.ang = QUARTER_Q16;
            end
            else
            begin
                v.a   = -b;
                v.b   = a;
                v.ang = -QUARTER_Q16;
            end
        end
        return v;
    endfunction

endpackage

FILE: design/normal_to_angle_bytes_core.sv
// Top level of the normal to angle bytes core: square-term stage, root cell chain,
// quadrant stage, two CORDIC cell chains and rounding stage. Depends on nta_pkg and cells.
//
//  channel   ports                   width  direction
//  request   start, busy, normal     48     in
//  result    done, angles            17     out
//
// One request per cycle; busy stays low. The path runs through one square-term
// stage, 24 root cells (one root bit each), one quadrant stage, 16 CORDIC cells
// per chain and one rounding stage. Reset clears only the valid chain. The
// receiver cannot stall: each result shows for one cycle with done.
module normal_to_angle_bytes_core (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    input  nta_pkg::req_t  normal,
    output logic           done,
    output nta_pkg::res_t  angles
);
    logic            in_valid_reg;
    nta_pkg::sqrt_t  in_data_reg;
    nta_pkg::sqrt_t  in_data_next;
    logic [30:0]     rad_w;

    logic            sq_valid [nta_pkg::SQRT_STEPS+1];
    nta_pkg::sqrt_t  sq_data  [nta_pkg::SQRT_STEPS+1];

    logic              pre_valid_reg;
    nta_pkg::cordic_t  pre_az_reg;
    nta_pkg::cordic_t  pre_el_reg;
    nta_pkg::cordic_t  pre_az_next;
    nta_pkg::cordic_t  pre_el_next;
    nta_pkg::sqrt_t    sq_last;

    logic              az_valid [nta_pkg::CORDIC_STAGES+1];
    nta_pkg::cordic_t  az_data  [nta_pkg::CORDIC_STAGES+1];
    logic              el_valid [nta_pkg::CORDIC_STAGES+1];
    nta_pkg::cordic_t  el_data  [nta_pkg::CORDIC_STAGES+1];

    logic              done_reg;
    nta_pkg::res_t     res_reg;
    nta_pkg::res_t     res_next;
    logic signed [nta_pkg::RND_W-1:0] r_az;
    logic signed [nta_pkg::RND_W-1:0] r_el;

    function automatic logic signed [nta_pkg::RND_W-1:0] round_deg(
        logic signed [nta_pkg::ANG_W-1:0] a);
        logic signed [nta_pkg::ANG_W:0] m;
        logic signed [nta_pkg::ANG_W:0] q;
        m = (a >= 0) ? (nta_pkg::ANG_W+1)'(a) : -(nta_pkg::ANG_W+1)'(a);
        q = (m + (nta_pkg::ANG_W+1)'(32768)) >>> 16;
        if (a < 0)
            q = -q;
        return q[nta_pkg::RND_W-1:0];
    endfunction

    assign busy = 1'b0;

    always_comb
    begin
        rad_w = 31'(32'sd1073741824 - 32'(normal.normal_y * normal.normal_y));
        in_data_next.req  = normal;
        in_data_next.rem  = '0;
        in_data_next.root = '0;
        in_data_next.rad  = {1'b0, rad_w, 16'b0};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else
            in_valid_reg <= start && !busy;
    end

    always_ff @(posedge clk)
    begin
        in_data_reg <= in_data_next;
    end

    assign sq_valid[0] = in_valid_reg;
    assign sq_data[0]  = in_data_reg;

    genvar i;
    generate
        for (i = 0; i < nta_pkg::SQRT_STEPS; i++)
        begin : g_sqrt
            nta_sqrt_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .in_valid  (sq_valid[i]),
                .in_data   (sq_data[i]),
                .out_valid (sq_valid[i+1]),
                .out_data  (sq_data[i+1])
            );
        end
    endgenerate

    always_comb
    begin
        sq_last = sq_data[nta_pkg::SQRT_STEPS];
        pre_az_next = nta_pkg::prerotate(
            nta_pkg::VEC_W'(sq_last.req.normal_x) <<< 8,
            nta_pkg::VEC_W'(sq_last.req.normal_z) <<< 8);
        pre_el_next = nta_pkg::prerotate(
            nta_pkg::VEC_W'(sq_last.req.normal_y) <<< 8,
            $signed(nta_pkg::VEC_W'(sq_last.root)));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pre_valid_reg <= 1'b0;
        else
            pre_valid_reg <= sq_valid[nta_pkg::SQRT_STEPS];
    end

    always_ff @(posedge clk)
    begin
        pre_az_reg <= pre_az_next;
        pre_el_reg <= pre_el_next;
    end

    assign az_valid[0] = pre_valid_reg;
    assign az_data[0]  = pre_az_reg;
    assign el_valid[0] = pre_valid_reg;
    assign el_data[0]  = pre_el_reg;

    generate
        for (i = 0; i < nta_pkg::CORDIC_STAGES; i++)
        begin : g_cordic
            nta_cordic_cell u_az (
                .clk       (clk),
                .rst_n     (rst_n),
                .stage     (nta_pkg::STAGE_W'(i)),
                .in_valid  (az_valid[i]),
                .in_data   (az_data[i]),
                .out_valid (az_valid[i+1]),
                .out_data  (az_data[i+1])
            );
            nta_cordic_cell u_el (
                .clk       (clk),
                .rst_n     (rst_n),
                .stage     (nta_pkg::STAGE_W'(i)),
                .in_valid  (el_valid[i]),
                .in_data   (el_data[i]),
                .out_valid (el_valid[i+1]),
                .out_data  (el_data[i+1])
            );
        end
    endgenerate

    always_comb
    begin
        r_az = az_data[nta_pkg::CORDIC_STAGES].zero ? '0
             : round_deg(az_data[nta_pkg::CORDIC_STAGES].ang);
        r_el = el_data[nta_pkg::CORDIC_STAGES].zero ? '0
             : round_deg(el_data[nta_pkg::CORDIC_STAGES].ang);
        res_next.azimuth_code    = r_az[7:0] ^ 8'h80;
        res_next.elevation_code  = r_el[7:0] ^ 8'h80;
        res_next.azimuth_wrapped = (r_az < -128) || (r_az > 127);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= az_valid[nta_pkg::CORDIC_STAGES];
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign done   = done_reg;
    assign angles = res_reg;

    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
        else $error("busy raised");
    a_chains_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        az_valid[nta_pkg::CORDIC_STAGES] == el_valid[nta_pkg::CORDIC_STAGES])
        else $error("cordic chains out of step");
    a_zero_az: assert property (@(posedge clk) disable iff (!rst_n)
        az_valid[nta_pkg::CORDIC_STAGES] && az_data[nta_pkg::CORDIC_STAGES].zero
        |=> done && angles.azimuth_code == 8'h80 && !angles.azimuth_wrapped)
        else $error("zero vector azimuth wrong");
endmodule

FILE: design/nta_sqrt_cell.sv
// One digit cell of the pipelined square root: one root bit per cycle.
// Depends on nta_pkg.
module nta_sqrt_cell (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  nta_pkg::sqrt_t in_data,
    output logic          out_valid,
    output nta_pkg::sqrt_t out_data
);
    logic            valid_reg;
    nta_pkg::sqrt_t  data_reg;
    nta_pkg::sqrt_t  data_next;
    logic [nta_pkg::REM_W-1:0] trial_rem;
    logic [nta_pkg::REM_W-1:0] trial_sub;

    always_comb
    begin
        trial_rem = {in_data.rem[nta_pkg::REM_W-3:0], in_data.rad[nta_pkg::RAD_W-1 -: 2]};
        trial_sub = nta_pkg::REM_W'({in_data.root, 2'b01});
        data_next = in_data;
        data_next.rad = {in_data.rad[nta_pkg::RAD_W-3:0], 2'b00};
        if (trial_rem >= trial_sub)
        begin
            data_next.rem  = trial_rem - trial_sub;
            data_next.root = {in_data.root[nta_pkg::ROOT_W-2:0], 1'b1};
        end
        else
        begin
            data_next.rem  = trial_rem;
            data_next.root = {in_data.root[nta_pkg::ROOT_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;
endmodule

FILE: design/nta_cordic_cell.sv
// One vectoring rotation of the CORDIC chain, registered.
// Depends on nta_pkg.
module nta_cordic_cell (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [nta_pkg::STAGE_W-1:0]   stage,
    input  logic                          in_valid,
    input  nta_pkg::cordic_t              in_data,
    output logic                          out_valid,
    output nta_pkg::cordic_t              out_data
);
    logic              valid_reg;
    nta_pkg::cordic_t  data_reg;
    nta_pkg::cordic_t  data_next;
    logic signed [nta_pkg::VEC_W-1:0] sa;
    logic signed [nta_pkg::VEC_W-1:0] sb;

    always_comb
    begin
        sa = in_data.a >>> stage;
        sb = in_data.b >>> stage;
        data_next = in_data;
        if (in_data.b >= 0)
        begin
            data_next.a   = in_data.a + sb;
            data_next.b   = in_data.b - sa;
            data_next.ang = in_data.ang + nta_pkg::ATAN_DEG_Q16[stage];
        end
        else
        begin
            data_next.a   = in_data.a - sb;
            data_next.b   = in_data.b + sa;
            data_next.ang = in_data.ang - nta_pkg::ATAN_DEG_Q16[stage];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;
endmodule
